// ===== rtl/rsve_pkg.sv =====
package rsve_pkg;

    localparam int UNIT_BITS      = 30;
    localparam int NORM_HI        = 24;
    localparam int DIV_W          = 64;
    localparam int DVR_W          = 26;
    localparam int SQ_W           = 50;
    localparam int U_W            = 50;
    localparam int OFF_W          = 33;
    localparam int MAX_POINTS_DEF = 1024;

    typedef enum logic [0:0] {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_op_t;

    typedef enum logic [2:0] {
        REG_POINTS   = 3'd0,
        REG_OFFSET_U = 3'd1,
        REG_OFFSET_V = 3'd2,
        REG_SCALE_U  = 3'd3,
        REG_SCALE_V  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                        done;
        logic [2:0][OFF_W-1:0]       off;
        logic [U_W-1:0]              u;
    } pair_res_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/ribbon_strip_vertex_expand.sv =====
// Turns a stream of polyline control points into triangle-strip vertices: each
// point gives a plus-side and a minus-side vertex, offset across the ribbon by
// half_width, with u running over the line and v set by side. A point's pair
// comes out when the next point arrives; the last point of a line also emits
// its own pair, so one input word gives zero, two or four output words.
// One point at a time: s_tready is low from acceptance until its last vertex
// has been taken. Each vertex pair is worked out by the single shared
// divide/square-root unit (ten divides and three roots for a full pair, fewer
// when the up vector is zero) plus one-bit-per-cycle block normalisation; a
// point that ends a line costs two pairs.
module ribbon_strip_vertex_expand #(
    parameter int MAX_POINTS = rsve_pkg::MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, up_x, up_y, up_z, half_width, rgba
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vert_x, vert_y, vert_z, tex_u, tex_v, vert_rgba
    output logic [191:0] m_tdata,
    // minus_side
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);
    import rsve_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_CALC  = 5'b00010,
        T_PLUS  = 5'b00100,
        T_MINUS = 5'b01000,
        T_UPD   = 5'b10000
    } tstate_t;

    tstate_t           state_reg, state_next;
    logic [10:0]       pil_reg;
    logic [31:0]       ofu_reg, ofv_reg, scu_reg, scv_reg;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic              last_reg, last_next;
    logic              pb_reg, pb_next;
    logic [2:0][31:0]  cpos_reg, cup_reg;
    logic [31:0]       cw_reg, crgba_reg;
    logic [2:0][31:0]  wpos0_reg, wpos1_reg, wup0_reg;
    logic [31:0]       ww0_reg, wrgba0_reg;

    logic [IDX_W-1:0]  cnt_m1;
    logic              s_acc, m_acc, cur_last, pstart;
    logic [2:0][31:0]  p_up, p_prev, p_pos;
    logic [31:0]       p_w, p_rgba;
    logic [IDX_W-1:0]  p_idx;
    pair_res_t         pres;
    logic [2:0][31:0]  vert;
    logic [31:0]       tv;
    logic signed [63:0] psum [3];

    always_comb begin
        if (pil_reg < 11'd2) begin
            cnt_m1 = IDX_W'(1);
        end else if (32'(pil_reg) > MAX_POINTS) begin
            cnt_m1 = IDX_W'(MAX_POINTS - 1);
        end else begin
            cnt_m1 = IDX_W'(pil_reg - 11'd1);
        end
    end

    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cur_last  = (pidx_reg >= cnt_m1);

    always_comb begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        i_next     = i_reg;
        last_next  = last_reg;
        pb_next    = pb_reg;
        pstart     = 1'b0;
        unique case (state_reg)
            T_IDLE: begin
                if (s_acc) begin
                    i_next    = pidx_reg;
                    last_next = cur_last;
                    if (pidx_reg != '0) begin
                        pb_next    = 1'b0;
                        pstart     = 1'b1;
                        state_next = T_CALC;
                    end else if (cur_last) begin
                        pb_next    = 1'b1;
                        pstart     = 1'b1;
                        state_next = T_CALC;
                    end else begin
                        state_next = T_UPD;
                    end
                end
            end
            T_CALC: begin
                if (pres.done) begin
                    state_next = T_PLUS;
                end
            end
            T_PLUS: begin
                if (m_acc) begin
                    state_next = T_MINUS;
                end
            end
            T_MINUS: begin
                if (m_acc) begin
                    if (!pb_reg && last_reg) begin
                        pb_next    = 1'b1;
                        pstart     = 1'b1;
                        state_next = T_CALC;
                    end else if (last_reg) begin
                        pidx_next  = '0;
                        state_next = T_IDLE;
                    end else begin
                        state_next = T_UPD;
                    end
                end
            end
            T_UPD: begin
                pidx_next  = i_reg + IDX_W'(1);
                state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= T_IDLE;
            pidx_reg   <= '0;
            pil_reg    <= 11'd2;
            ofu_reg    <= '0;
            ofv_reg    <= '0;
            scu_reg    <= 32'd65536;
            scv_reg    <= 32'd65536;
            wpos0_reg  <= '0;
            wpos1_reg  <= '0;
            wup0_reg   <= '0;
            ww0_reg    <= '0;
            wrgba0_reg <= '0;
        end else begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    REG_POINTS:   pil_reg <= cfg_data[10:0];
                    REG_OFFSET_U: ofu_reg <= cfg_data;
                    REG_OFFSET_V: ofv_reg <= cfg_data;
                    REG_SCALE_U:  scu_reg <= cfg_data;
                    REG_SCALE_V:  scv_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == T_UPD) begin
                wpos1_reg  <= wpos0_reg;
                wpos0_reg  <= cpos_reg;
                wup0_reg   <= cup_reg;
                ww0_reg    <= cw_reg;
                wrgba0_reg <= crgba_reg;
            end
        end
        i_reg    <= i_next;
        last_reg <= last_next;
        pb_reg   <= pb_next;
        if (s_acc) begin
            cpos_reg  <= s_tdata[95:0];
            cup_reg   <= s_tdata[191:96];
            cw_reg    <= s_tdata[223:192];
            crgba_reg <= s_tdata[255:224];
        end
    end

    always_comb begin
        if (pb_reg) begin
            p_pos  = cpos_reg;
            p_up   = cup_reg;
            p_prev = (i_reg != '0) ? wpos0_reg : cpos_reg;
            p_w    = cw_reg;
            p_rgba = crgba_reg;
            p_idx  = i_reg;
        end else begin
            p_pos  = wpos0_reg;
            p_up   = wup0_reg;
            p_prev = (i_reg > IDX_W'(1)) ? wpos1_reg : wpos0_reg;
            p_w    = ww0_reg;
            p_rgba = wrgba0_reg;
            p_idx  = i_reg - IDX_W'(1);
        end
    end

    rsve_pair #(
        .IDX_W (IDX_W)
    ) u_pair (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pstart),
        .up       (p_up),
        .prev     (p_prev),
        .next     (cpos_reg),
        .w        (p_w),
        .idx      (p_idx),
        .cnt_m1   (cnt_m1),
        .scale_u  (scu_reg),
        .offset_u (ofu_reg),
        .res      (pres)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (state_reg == T_MINUS) begin
                psum[i] = {{32{p_pos[i][31]}}, p_pos[i]}
                          - {{(64-OFF_W){pres.off[i][OFF_W-1]}}, pres.off[i]};
            end else begin
                psum[i] = {{32{p_pos[i][31]}}, p_pos[i]}
                          + {{(64-OFF_W){pres.off[i][OFF_W-1]}}, pres.off[i]};
            end
            vert[i] = sat32(psum[i]);
        end
        if (state_reg == T_MINUS) begin
            tv = sat32({{32{ofv_reg[31]}}, ofv_reg} + {{32{scv_reg[31]}}, scv_reg});
        end else begin
            tv = ofv_reg;
        end
    end

    assign m_tvalid = (state_reg == T_PLUS) || (state_reg == T_MINUS);
    assign m_tuser  = (state_reg == T_MINUS);
    assign m_tlast  = (state_reg == T_MINUS) && pb_reg;
    assign m_tdata  = {p_rgba, tv,
                       sat32({{(64-U_W){pres.u[U_W-1]}}, pres.u}),
                       vert[2], vert[1], vert[0]};

    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a vertex is pending");

    a_last_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tuser)
        else $error("line end on a plus-side vertex");

    a_done_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        pres.done |-> (state_reg == T_CALC))
        else $error("pair finished outside calculation");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pstart |=> (state_reg == T_CALC))
        else $error("pair started without waiting for it");

endmodule

// ===== rtl/rsve_divsqrt.sv =====
module rsve_divsqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  rsve_pkg::ds_op_t          op,
    input  logic [rsve_pkg::DIV_W-1:0] num,
    input  logic [rsve_pkg::DVR_W-1:0] dvr,
    output logic                      done,
    output logic [rsve_pkg::DIV_W-1:0] res
);
    import rsve_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    ds_op_t           op_reg, op_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0] acc_reg, acc_next;
    logic [DVR_W-1:0] rem_reg, rem_next;
    logic [DVR_W-1:0] dvr_reg, dvr_next;
    logic [SQ_W-1:0]  root_reg, root_next;
    logic [SQ_W-1:0]  bit_reg, bit_next;

    logic [DVR_W:0]   trial;
    logic [DVR_W:0]   trial_sub;
    logic [SQ_W-1:0]  sq_s;
    logic [SQ_W-1:0]  sq_rb;

    always_comb begin
        trial     = {rem_reg, acc_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, dvr_reg};
        sq_s      = acc_reg[SQ_W-1:0];
        sq_rb     = root_reg + bit_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        root_next = root_reg;
        bit_next  = bit_reg;

        if (start) begin
            busy_next = 1'b1;
            op_next   = op;
            acc_next  = num;
            rem_next  = '0;
            dvr_next  = dvr;
            root_next = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            cnt_next  = (op == DS_SQRT) ? 7'(SQ_W / 2) : 7'(DIV_W);
        end else if (busy_reg) begin
            unique case (op_reg)
                DS_DIV: begin
                    if (trial >= {1'b0, dvr_reg}) begin
                        rem_next = trial_sub[DVR_W-1:0];
                        acc_next = {acc_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_next = trial[DVR_W-1:0];
                        acc_next = {acc_reg[DIV_W-2:0], 1'b0};
                    end
                end
                DS_SQRT: begin
                    if (sq_s >= sq_rb) begin
                        acc_next  = {{(DIV_W-SQ_W){1'b0}}, sq_s - sq_rb};
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                default: ;
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= DS_DIV;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dvr_reg  <= dvr_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign res  = (op_reg == DS_SQRT) ? {{(DIV_W-SQ_W){1'b0}}, root_reg} : acc_reg;

endmodule

// ===== rtl/rsve_pair.sv =====
module rsve_pair #(
    parameter int IDX_W = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [2:0][31:0]        up,
    input  logic [2:0][31:0]        prev,
    input  logic [2:0][31:0]        next,
    input  logic [31:0]             w,
    input  logic [IDX_W-1:0]        idx,
    input  logic [IDX_W-1:0]        cnt_m1,
    input  logic [31:0]             scale_u,
    input  logic [31:0]             offset_u,
    output rsve_pkg::pair_res_t     res
);
    import rsve_pkg::*;

    typedef enum logic [13:0] {
        P_IDLE   = 14'b00000000000001,
        P_UVMUL  = 14'b00000000000010,
        P_UVGO   = 14'b00000000000100,
        P_UVWAIT = 14'b00000000001000,
        P_LOAD   = 14'b00000000010000,
        P_SHIFT  = 14'b00000000100000,
        P_SQ     = 14'b00000001000000,
        P_SQGO   = 14'b00000010000000,
        P_SQWAIT = 14'b00000100000000,
        P_DVGO   = 14'b00001000000000,
        P_DVWAIT = 14'b00010000000000,
        P_CROSS  = 14'b00100000000000,
        P_OFF    = 14'b01000000000000,
        P_DONE   = 14'b10000000000000
    } pstate_t;

    typedef enum logic [2:0] {
        PH_UP    = 3'b001,
        PH_DIR   = 3'b010,
        PH_CROSS = 3'b100
    } phase_t;

    pstate_t                state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [2:0]             k_reg, k_next;
    logic [62:0]            mag_reg [3];
    logic [62:0]            mag_next [3];
    logic                   neg_reg [3];
    logic                   neg_next [3];
    logic [SQ_W-1:0]        s_reg, s_next;
    logic [24:0]            len_reg, len_next;
    logic                   uneg_reg, uneg_next;
    logic signed [63:0]     prod_reg;
    logic signed [31:0]     un_reg [3];
    logic signed [31:0]     un_next [3];
    logic signed [31:0]     ud_reg [3];
    logic signed [31:0]     ud_next [3];
    logic signed [31:0]     uc_reg [3];
    logic signed [31:0]     uc_next [3];
    logic signed [63:0]     c_reg [3];
    logic signed [63:0]     c_next [3];
    logic [OFF_W-1:0]       off_reg [3];
    logic [OFF_W-1:0]       off_next [3];
    logic [U_W-1:0]         u_reg, u_next;

    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_p;
    logic signed [63:0]     vsrc [3];
    logic [1:0]             ksel, kprev;
    logic                   ds_start, ds_done;
    ds_op_t                 ds_op;
    logic [DIV_W-1:0]       ds_num, ds_res;
    logic [DVR_W-1:0]       ds_dvr;
    logic [63:0]            uabs;
    logic [U_W-1:0]         uq;
    logic [31:0]            dq;
    logic signed [63:0]     trunc_p;
    logic                   any_hi, all_lo;

    rsve_divsqrt u_ds (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .op      (ds_op),
        .num     (ds_num),
        .dvr     (ds_dvr),
        .done    (ds_done),
        .res     (ds_res)
    );

    always_comb begin
        ksel  = (k_reg < 3'd3) ? k_reg[1:0] : 2'd0;
        kprev = (k_reg != 3'd0 && k_reg < 3'd4) ? 2'(k_reg - 3'd1) : 2'd0;
        for (int i = 0; i < 3; i++) begin
            unique case (phase_reg)
                PH_UP:    vsrc[i] = {{32{up[i][31]}}, up[i]};
                PH_DIR:   vsrc[i] = {{32{next[i][31]}}, next[i]}
                                    - {{32{prev[i][31]}}, prev[i]};
                PH_CROSS: vsrc[i] = c_reg[i];
                default:  vsrc[i] = '0;
            endcase
        end
        any_hi = (mag_reg[0][62:NORM_HI] != '0) || (mag_reg[1][62:NORM_HI] != '0)
                 || (mag_reg[2][62:NORM_HI] != '0);
        all_lo = (mag_reg[0][62:NORM_HI-1] == '0) && (mag_reg[1][62:NORM_HI-1] == '0)
                 && (mag_reg[2][62:NORM_HI-1] == '0);

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            P_UVMUL: begin
                mul_a = {scale_u[31], scale_u};
                mul_b = $signed({{(33-IDX_W){1'b0}}, idx});
            end
            P_SQ: begin
                mul_a = $signed({9'b0, mag_reg[ksel][NORM_HI-1:0]});
                mul_b = $signed({9'b0, mag_reg[ksel][NORM_HI-1:0]});
            end
            P_CROSS: begin
                unique case (k_reg)
                    3'd0: begin mul_a = 33'(un_reg[1]); mul_b = 33'(ud_reg[2]); end
                    3'd1: begin mul_a = 33'(un_reg[2]); mul_b = 33'(ud_reg[1]); end
                    3'd2: begin mul_a = 33'(un_reg[2]); mul_b = 33'(ud_reg[0]); end
                    3'd3: begin mul_a = 33'(un_reg[0]); mul_b = 33'(ud_reg[2]); end
                    3'd4: begin mul_a = 33'(un_reg[0]); mul_b = 33'(ud_reg[1]); end
                    3'd5: begin mul_a = 33'(un_reg[1]); mul_b = 33'(ud_reg[0]); end
                    default: ;
                endcase
            end
            P_OFF: begin
                mul_a = {w[31], w};
                mul_b = 33'(uc_reg[ksel]);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;

        uabs   = prod_reg[63] ? 64'(-prod_reg) : prod_reg;
        ds_start = (state_reg == P_UVGO) || (state_reg == P_SQGO) || (state_reg == P_DVGO);
        ds_op    = (state_reg == P_SQGO) ? DS_SQRT : DS_DIV;
        unique case (state_reg)
            P_UVGO: ds_num = uabs;
            P_SQGO: ds_num = {{(DIV_W-SQ_W){1'b0}}, s_reg};
            default: ds_num = {{(DIV_W-NORM_HI-UNIT_BITS){1'b0}},
                               mag_reg[ksel][NORM_HI-1:0], {UNIT_BITS{1'b0}}};
        endcase
        ds_dvr = (state_reg == P_UVGO) ? DVR_W'(cnt_m1) : {1'b0, len_reg};

        uq = {2'b0, ds_res[U_W-3:0]};
        dq = ds_res[31:0];
        trunc_p = prod_reg + (prod_reg[63] ? 64'((64'd1 << UNIT_BITS) - 64'd1) : 64'd0);

        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        len_next   = len_reg;
        uneg_next  = uneg_reg;
        u_next     = u_reg;
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
            un_next[i]  = un_reg[i];
            ud_next[i]  = ud_reg[i];
            uc_next[i]  = uc_reg[i];
            c_next[i]   = c_reg[i];
            off_next[i] = off_reg[i];
        end

        unique case (state_reg)
            P_IDLE: begin
                if (start) begin
                    state_next = P_UVMUL;
                end
            end
            P_UVMUL: state_next = P_UVGO;
            P_UVGO: begin
                uneg_next  = prod_reg[63];
                state_next = P_UVWAIT;
            end
            P_UVWAIT: begin
                if (ds_done) begin
                    u_next = {{(U_W-32){offset_u[31]}}, offset_u}
                             + (uneg_reg ? U_W'(-uq) : uq);
                    phase_next = PH_UP;
                    state_next = P_LOAD;
                end
            end
            P_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    neg_next[i] = vsrc[i][63];
                    mag_next[i] = vsrc[i][63] ? 63'(-vsrc[i]) : vsrc[i][62:0];
                end
                if (vsrc[0] == '0 && vsrc[1] == '0 && vsrc[2] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        off_next[i] = '0;
                    end
                    state_next = P_DONE;
                end else begin
                    state_next = P_SHIFT;
                end
            end
            P_SHIFT: begin
                if (any_hi) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end else if (all_lo) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end else begin
                    k_next     = '0;
                    s_next     = '0;
                    state_next = P_SQ;
                end
            end
            P_SQ: begin
                if (k_reg != 3'd0) begin
                    s_next = s_reg + SQ_W'(prod_reg[2*NORM_HI-1:0]);
                end
                if (k_reg == 3'd3) begin
                    state_next = P_SQGO;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            P_SQGO: state_next = P_SQWAIT;
            P_SQWAIT: begin
                if (ds_done) begin
                    len_next   = ds_res[24:0];
                    k_next     = '0;
                    state_next = P_DVGO;
                end
            end
            P_DVGO: state_next = P_DVWAIT;
            P_DVWAIT: begin
                if (ds_done) begin
                    unique case (phase_reg)
                        PH_UP:    un_next[ksel] = neg_reg[ksel] ? -dq : dq;
                        PH_DIR:   ud_next[ksel] = neg_reg[ksel] ? -dq : dq;
                        PH_CROSS: uc_next[ksel] = neg_reg[ksel] ? -dq : dq;
                        default: ;
                    endcase
                    if (k_reg == 3'd2) begin
                        k_next = '0;
                        unique case (phase_reg)
                            PH_UP: begin
                                phase_next = PH_DIR;
                                state_next = P_LOAD;
                            end
                            PH_DIR: begin
                                phase_next = PH_CROSS;
                                state_next = P_CROSS;
                            end
                            default: state_next = P_OFF;
                        endcase
                    end else begin
                        k_next     = k_reg + 3'd1;
                        state_next = P_DVGO;
                    end
                end
            end
            P_CROSS: begin
                if (k_reg != 3'd0) begin
                    if (k_reg[0]) begin
                        c_next[2'((k_reg - 3'd1) >> 1)] = prod_reg;
                    end else begin
                        c_next[2'((k_reg - 3'd1) >> 1)] =
                            c_reg[2'((k_reg - 3'd1) >> 1)] - prod_reg;
                    end
                end
                if (k_reg == 3'd6) begin
                    state_next = P_LOAD;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            P_OFF: begin
                if (k_reg != 3'd0) begin
                    off_next[kprev] = trunc_p[UNIT_BITS+OFF_W-1:UNIT_BITS];
                end
                if (k_reg == 3'd3) begin
                    state_next = P_DONE;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            P_DONE: state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            phase_reg <= PH_UP;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
        prod_reg <= mul_p[63:0];
        s_reg    <= s_next;
        len_reg  <= len_next;
        uneg_reg <= uneg_next;
        u_reg    <= u_next;
        for (int i = 0; i < 3; i++) begin
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
            un_reg[i]  <= un_next[i];
            ud_reg[i]  <= ud_next[i];
            uc_reg[i]  <= uc_next[i];
            c_reg[i]   <= c_next[i];
            off_reg[i] <= off_next[i];
        end
    end

    assign res.done   = (state_reg == P_DONE);
    assign res.off[0] = off_reg[0];
    assign res.off[1] = off_reg[1];
    assign res.off[2] = off_reg[2];
    assign res.u      = u_reg;

endmodule

// ===== tb/ribbon_strip_vertex_expand_tb.sv =====
`timescale 1ns / 1ps

module ribbon_strip_vertex_expand_tb;
    import rsve_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic [31:0] vx, vy, vz, tu, tv, rgba;
        logic        minus, line_end;
    } vertex_t;

    class ribbon_scoreboard;
        logic [10:0] pts_per_line;
        logic [31:0] off_u, off_v, scale_u, scale_v;
        vec3_t       held_pos, held_up, older_pos;
        longint      held_width;
        logic [31:0] held_rgba;
        int          pt_idx;
        vertex_t     pending[$];
        int          errors;
        int          results_seen;

        function new();
            pts_per_line = 11'd2;
            off_u = 0;
            off_v = 0;
            scale_u = 32'd65536;
            scale_v = 32'd65536;
            for (int i = 0; i < 3; i++) begin
                held_pos[i] = 0;
                held_up[i] = 0;
                older_pos[i] = 0;
            end
            held_width = 0;
            held_rgba = 0;
            pt_idx = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void note_config(cfg_reg_t a, logic [31:0] d);
            case (a)
                REG_POINTS:   pts_per_line = d[10:0];
                REG_OFFSET_U: off_u = d;
                REG_OFFSET_V: off_v = d;
                REG_SCALE_U:  scale_u = d;
                REG_SCALE_V:  scale_v = d;
                default: ;
            endcase
        endfunction

        function int line_len();
            int c;
            c = pts_per_line;
            if (c < 2) c = 2;
            if (c > MAX_POINTS_DEF) c = MAX_POINTS_DEF;
            return c;
        endfunction

        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // block normalisation to Q2.30; 0 when the vector is zero
        function bit unit_dir(input vec3_t v, output vec3_t u);
            longint unsigned mag [3];
            longint unsigned m, s, len;
            bit              neg [3];
            longint          q;
            m = 0;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = v[i] < 0;
                mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
                if (mag[i] > m) m = mag[i];
                u[i] = 0;
            end
            if (m == 0) return 0;
            while (m >= (64'd1 << NORM_HI)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (m < (64'd1 << (NORM_HI - 1))) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = longint'((mag[i] << UNIT_BITS) / len);
                u[i] = neg[i] ? -q : q;
            end
            return 1;
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7fff_ffff;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function void add_pair(vec3_t pos, vec3_t up, vec3_t prv, vec3_t nxt, longint w,
                               logic [31:0] rgba, int idx, bit ends);
            vec3_t   d, un, ud, c, uc, off;
            longint  u, vp, vm;
            vertex_t vt;
            for (int i = 0; i < 3; i++) begin
                d[i] = nxt[i] - prv[i];
                off[i] = 0;
            end
            if (unit_dir(up, un) && unit_dir(d, ud)) begin
                c[0] = un[1] * ud[2] - un[2] * ud[1];
                c[1] = un[2] * ud[0] - un[0] * ud[2];
                c[2] = un[0] * ud[1] - un[1] * ud[0];
                if (unit_dir(c, uc))
                    for (int i = 0; i < 3; i++) off[i] = (w * uc[i]) / (64'sd1 << UNIT_BITS);
            end
            u = longint'($signed(off_u)) + (longint'($signed(scale_u)) * idx)
                / longint'(line_len() - 1);
            vp = longint'($signed(off_v));
            vm = vp + longint'($signed(scale_v));
            for (int s = 0; s < 2; s++) begin
                vt.vx = clamp32(s == 0 ? pos[0] + off[0] : pos[0] - off[0]);
                vt.vy = clamp32(s == 0 ? pos[1] + off[1] : pos[1] - off[1]);
                vt.vz = clamp32(s == 0 ? pos[2] + off[2] : pos[2] - off[2]);
                vt.tu = clamp32(u);
                vt.tv = clamp32(s == 0 ? vp : vm);
                vt.rgba = rgba;
                vt.minus = s;
                vt.line_end = (s == 1) && ends;
                pending = {pending, vt};
            end
        endfunction

        function void note_point(logic [255:0] d);
            vec3_t  cp, cu, prv;
            longint cw;
            bit     ends;
            for (int j = 0; j < 3; j++) begin
                cp[j] = longint'($signed(d[32*j +: 32]));
                cu[j] = longint'($signed(d[32*(3+j) +: 32]));
            end
            cw = longint'($signed(d[223:192]));
            ends = pt_idx >= line_len() - 1;
            if (pt_idx > 0) begin
                prv = (pt_idx > 1) ? older_pos : held_pos;
                add_pair(held_pos, held_up, prv, cp, held_width, held_rgba, pt_idx - 1, 0);
            end
            if (ends) begin
                prv = (pt_idx > 0) ? held_pos : cp;
                add_pair(cp, cu, prv, cp, cw, d[255:224], pt_idx, 1);
                pt_idx = 0;
            end else begin
                older_pos = held_pos;
                held_pos = cp;
                held_up = cu;
                held_width = cw;
                held_rgba = d[255:224];
                pt_idx++;
            end
        endfunction

        function void check_vertex(logic [191:0] d, logic minus, logic lst);
            vertex_t e;
            results_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h user %b last %b", d, minus, lst);
                return;
            end
            e = pending.pop_front();
            if (d !== {e.rgba, e.tv, e.tu, e.vz, e.vy, e.vx} || minus !== e.minus
                || lst !== e.line_end) begin
                errors++;
                if (errors <= 10)
                    $display("word %0d: exp %h/%b/%b got %h/%b/%b", results_seen,
                             {e.rgba, e.tv, e.tu, e.vz, e.vy, e.vx}, e.minus, e.line_end,
                             d, minus, lst);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE = 2000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [191:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;

    ribbon_scoreboard strip_sb = new();
    int cycles = 0;
    int points_sent = 0;

    ribbon_strip_vertex_expand dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ribbon_strip_vertex_expand: mismatch");
            $finish;
        end
    end

    function int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    endfunction

    initial begin : vertex_sink
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = draw_gap();
            if (gap > 0) begin
                m_tready = 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
            strip_sb.check_vertex(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic write_reg(cfg_reg_t a, logic [31:0] d);
        cfg_addr = a;
        cfg_data = d;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        strip_sb.note_config(a, d);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_point(logic [31:0] px, py, pz, ux, uy, uz, w, rgba);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {rgba, w, uz, uy, ux, pz, py, px};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        strip_sb.note_point(s_tdata);
        points_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (strip_sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    function logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 0;
            default: return $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
        endcase
    endfunction

    function logic [31:0] rand_cfg();
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
        endcase
    endfunction

    initial begin : stimulus
        int counts [9] = '{2, 3, 5, 7, 1, 0, 2047, 1024, 17};
        logic [31:0] base [3];
        logic [31:0] up_v [3];
        logic [31:0] w;
        int k;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        write_reg(REG_POINTS, 32'd4);
        write_reg(REG_OFFSET_U, 32'd0);
        write_reg(REG_OFFSET_V, 32'd0);
        write_reg(REG_SCALE_U, 32'd65536);
        write_reg(REG_SCALE_V, 32'd65536);

        // straight line, then a repeated point
        send_point(0, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 32'h0);
        send_point(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 32'hffff_ffff);
        send_point(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 32'h8000, 32'h1234_5678);
        send_point(32'h3_0000, 32'h2_0000, 0, 0, 0, 32'h1_0000, 32'hffff_8000, 32'h1);
        // zero up, up along the line, negative width
        send_point(0, 0, 0, 0, 0, 0, 32'h1_0000, 32'haa55_aa55);
        send_point(0, 32'h1_0000, 0, 0, 32'h1_0000, 0, 32'h2_0000, 32'h55aa_55aa);
        send_point(0, 32'h2_0000, 0, 32'h1_0000, 0, 0, 32'h8000_0000, 32'h0);
        send_point(0, 32'h2_0000, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h0);
        // saturation at the extremes
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 0,
                   32'h7fff_ffff, 32'h8000_0001);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 32'h1,
                   32'h1, 32'h7fff_fffe);
        send_point(32'h10, 32'h20, 32'h30, 32'h1, 32'h2, 32'h3, 32'h1_0000, 32'hffff_ffff);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_POINTS, counts[ph]);
            write_reg(REG_OFFSET_U, ph == 2 ? 32'h7fff_ffff : rand_cfg());
            write_reg(REG_OFFSET_V, ph == 3 ? 32'h8000_0000 : rand_cfg());
            write_reg(REG_SCALE_U, ph == 4 ? 32'h8000_0000 : rand_cfg());
            write_reg(REG_SCALE_V, ph == 5 ? 32'h7fff_ffff : rand_cfg());
            for (int j = 0; j < 3; j++) begin
                base[j] = rand_coord();
                up_v[j] = $urandom();
            end
            w = rand_coord();
            for (int n = 0; n < 20; n++) begin
                k = $urandom_range(0, 9);
                if (k < 7) begin
                    // smooth walk with occasional shared points
                    if (k != 0)
                        for (int j = 0; j < 3; j++)
                            base[j] = base[j] + ($signed($urandom_range(0, 32'h3_ffff))
                                                 - 32'sh2_0000);
                    if ($urandom_range(0, 3) == 0)
                        for (int j = 0; j < 3; j++) up_v[j] = rand_coord();
                    send_point(base[0], base[1], base[2], up_v[0], up_v[1], up_v[2], w,
                               $urandom());
                end else begin
                    send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(), $urandom());
                end
            end
            drain();
        end

        $display("%0d control points sent over ten register settings, %0d vertices checked",
                 points_sent, strip_sb.results_seen);
        if (strip_sb.errors == 0) begin
            $display("ribbon_strip_vertex_expand: match");
        end else begin
            $display("%0d vertices wrong", strip_sb.errors);
            $display("ribbon_strip_vertex_expand: mismatch");
        end
        $finish;
    end

endmodule
